### src/fdt_pkg.sv
// Shared constants, types and digit helpers for the frequency to decimal text converter.
package fdt_pkg;

	// Widths of the stream payloads and of the intermediate values.
	localparam int unsigned FREQ_W  = 32;
	localparam int unsigned CHAR_W  = 6;
	localparam int unsigned QUOT_W  = 23;   // holds (2^32 - 1) / 1000
	localparam int unsigned REM_W   = 10;   // holds a remainder below 1000
	localparam int unsigned MHZ_W   = 13;   // holds (2^32 - 1) / 1000000
	localparam int unsigned HUND_W  = 6;    // hundreds count of a value below 4295
	localparam int unsigned REST_W  = 7;    // remainder below 100
	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned PROD_W  = FREQ_W + 29;

	// Divide by 1000: floor(n * ceil(2^38 / 1000) / 2^38), then one correction step.
	localparam int unsigned DIV1000       = 1000;
	localparam int unsigned DIV1000_RECIP = 274877907;
	localparam int unsigned DIV1000_SHIFT = 38;

	// Divide by 100 for values below 4295, and by 10 for values below 100.
	localparam int unsigned DIV100        = 100;
	localparam int unsigned DIV100_RECIP  = 5243;
	localparam int unsigned DIV10         = 10;
	localparam int unsigned DIV10_RECIP   = 205;

	localparam int unsigned ASCII_ZERO = 48;
	localparam int unsigned ASCII_DOT  = 46;

	// One result text; the first character sits in the lowest bits.
	typedef struct packed {
		logic [CHAR_W-1:0] hz_tens_char;
		logic [CHAR_W-1:0] hz_hundreds_char;
		logic [CHAR_W-1:0] second_dot_char;
		logic [CHAR_W-1:0] khz_units_char;
		logic [CHAR_W-1:0] khz_tens_char;
		logic [CHAR_W-1:0] khz_hundreds_char;
		logic [CHAR_W-1:0] first_dot_char;
		logic [CHAR_W-1:0] mhz_units_char;
		logic [CHAR_W-1:0] mhz_tens_char;
		logic [CHAR_W-1:0] mhz_hundreds_char;
	} text_t;

	// A value below 4295 taken apart into its hundreds and the rest below 100.
	typedef struct packed {
		logic [HUND_W-1:0] hund;
		logic [REST_W-1:0] rest;
	} split_t;

	// Splits off the hundreds by a reciprocal multiplication.
	function automatic split_t split_hundreds(input logic [MHZ_W-1:0] v);
		logic [24:0]       p;
		logic [HUND_W-1:0] h;
		split_t            res;
		p = 25'(v) * 25'(DIV100_RECIP);
		h = p[24:19];
		res.hund = h;
		res.rest = REST_W'(v - MHZ_W'(h) * MHZ_W'(DIV100));
		return res;
	endfunction

	// Quotient by ten of a value below 100.
	function automatic logic [DIGIT_W-1:0] div10(input logic [REST_W-1:0] v);
		logic [14:0] p;
		p = 15'(v) * 15'(DIV10_RECIP);
		return p[14:11];
	endfunction

	// Lowest decimal digit of a value below 100.
	function automatic logic [DIGIT_W-1:0] mod10(input logic [REST_W-1:0] v);
		logic [DIGIT_W-1:0] t;
		t = div10(v);
		return DIGIT_W'(v - REST_W'(t) * REST_W'(DIV10));
	endfunction

	// ASCII code of one decimal digit.
	function automatic logic [CHAR_W-1:0] ascii_digit(input logic [DIGIT_W-1:0] d);
		return CHAR_W'(ASCII_ZERO) + CHAR_W'(d);
	endfunction

endpackage

### src/frequency_to_decimal_text.sv
// Top level of the frequency to decimal text converter (MMM.KKK.HH).
//
//   channel   direction   payload
//   s_*       in          tdata[31:0] frequency_hz
//   m_*       out         tdata[63:0] ten ASCII characters, six bits each
//
// Each divide by 1000 has a multiply and a correct stage, then the digit
// split stages follow. Every stage has its own valid bit and moves
// independently: one transfer is taken per cycle while m_tready is high.
// Reset clears the valid bits only. While m_tready is low the pipeline
// keeps filling its empty stages and s_tready falls once all are full.
module frequency_to_decimal_text import fdt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] frequency_hz
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] mhz_hundreds_char, [11:6] mhz_tens_char, [17:12] mhz_units_char,
	// [23:18] first_dot_char, [29:24] khz_hundreds_char, [35:30] khz_tens_char,
	// [41:36] khz_units_char, [47:42] second_dot_char, [53:48] hz_hundreds_char,
	// [59:54] hz_tens_char, [63:60] zero
	output logic [63:0] m_tdata
);

	logic              a_valid, a_ready;
	logic [QUOT_W-1:0] a_quot;
	logic [REM_W-1:0]  a_rem;
	logic [REM_W-1:0]  a_side;
	logic              b_valid, b_ready;
	logic [QUOT_W-1:0] b_quot;
	logic [REM_W-1:0]  b_rem;
	logic [REM_W-1:0]  b_side;
	text_t             text;

	// Hertz into kilohertz and the hertz below one kilohertz.
	fdt_div1000 u_div_hz (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_num    (s_tdata),
		.in_side   ('0),
		.out_valid (a_valid),
		.out_ready (a_ready),
		.out_quot  (a_quot),
		.out_rem   (a_rem),
		.out_side  (a_side)
	);

	// Kilohertz into megahertz and the kilohertz below one megahertz.
	fdt_div1000 u_div_khz (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (a_valid),
		.in_ready  (a_ready),
		.in_num    (FREQ_W'(a_quot)),
		.in_side   (a_rem),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_quot  (b_quot),
		.out_rem   (b_rem),
		.out_side  (b_side)
	);

	// The three groups into characters; a_side carries nothing.
	fdt_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.in_mhz    (b_quot[MHZ_W-1:0]),
		.in_khz    (b_rem),
		.in_hz     (b_side ^ a_side ^ a_side),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_text  (text)
	);

	assign m_tdata = {4'b0000, text};

endmodule

### src/fdt_div1000.sv
// Two-stage divide by 1000 with a carried side value, one transfer per cycle while out_ready is high.
module fdt_div1000 import fdt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FREQ_W-1:0] in_num,
	input  logic [REM_W-1:0]  in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [QUOT_W-1:0] out_quot,
	output logic [REM_W-1:0]  out_rem,
	output logic [REM_W-1:0]  out_side
);

	logic              v_s1, v_s2;
	logic              rdy_s1, rdy_s2;
	logic [FREQ_W-1:0] num_s1, num_s2;
	logic [REM_W-1:0]  side_s1, side_s2;
	logic [QUOT_W-1:0] quot_s2;
	logic [PROD_W-1:0] prod;
	logic [FREQ_W-1:0] back;
	logic [FREQ_W-1:0] rem_full;

	// A stage takes new data when it is empty or its content moves on.
	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Estimate of the quotient by the reciprocal product.
	assign prod = PROD_W'(num_s1) * PROD_W'(DIV1000_RECIP);

	// Payload of both stages.
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			num_s1  <= in_num;
			side_s1 <= in_side;
		end
		if (rdy_s2 && v_s1) begin
			num_s2  <= num_s1;
			side_s2 <= side_s1;
			quot_s2 <= prod[DIV1000_SHIFT+QUOT_W-1:DIV1000_SHIFT];
		end
	end

	// Remainder, with one correction step should the estimate fall short.
	assign back     = FREQ_W'(quot_s2) * FREQ_W'(DIV1000);
	assign rem_full = num_s2 - back;

	always_comb begin
		if (rem_full >= FREQ_W'(DIV1000)) begin
			out_quot = quot_s2 + QUOT_W'(1);
			out_rem  = REM_W'(rem_full - FREQ_W'(DIV1000));
		end else begin
			out_quot = quot_s2;
			out_rem  = REM_W'(rem_full);
		end
	end

	assign out_valid = v_s2;
	assign out_side  = side_s2;

endmodule

### src/fdt_digits.sv
// Three-stage split of megahertz, kilohertz and hertz values into ASCII digits.
module fdt_digits import fdt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [MHZ_W-1:0] in_mhz,
	input  logic [REM_W-1:0] in_khz,
	input  logic [REM_W-1:0] in_hz,
	output logic             out_valid,
	input  logic             out_ready,
	output text_t            out_text
);

	logic             v_s1, v_s2, v_s3;
	logic             rdy_s1, rdy_s2, rdy_s3;
	logic [MHZ_W-1:0] mhz_s1;
	logic [REM_W-1:0] khz_s1, hz_s1;
	split_t           mhz_s2, khz_s2, hz_s2;
	text_t            text_s3;
	text_t            text_d;

	// A stage takes new data when it is empty or its content moves on.
	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Final characters from the hundreds and the remainders below 100.
	always_comb begin
		text_d.mhz_hundreds_char = ascii_digit(mod10(REST_W'(mhz_s2.hund)));
		text_d.mhz_tens_char     = ascii_digit(div10(mhz_s2.rest));
		text_d.mhz_units_char    = ascii_digit(mod10(mhz_s2.rest));
		text_d.first_dot_char    = CHAR_W'(ASCII_DOT);
		text_d.khz_hundreds_char = ascii_digit(DIGIT_W'(khz_s2.hund));
		text_d.khz_tens_char     = ascii_digit(div10(khz_s2.rest));
		text_d.khz_units_char    = ascii_digit(mod10(khz_s2.rest));
		text_d.second_dot_char   = CHAR_W'(ASCII_DOT);
		text_d.hz_hundreds_char  = ascii_digit(DIGIT_W'(hz_s2.hund));
		text_d.hz_tens_char      = ascii_digit(div10(hz_s2.rest));
	end

	// Payload of the three stages.
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mhz_s1 <= in_mhz;
			khz_s1 <= in_khz;
			hz_s1  <= in_hz;
		end
		if (rdy_s2 && v_s1) begin
			mhz_s2 <= split_hundreds(mhz_s1);
			khz_s2 <= split_hundreds(MHZ_W'(khz_s1));
			hz_s2  <= split_hundreds(MHZ_W'(hz_s1));
		end
		if (rdy_s3 && v_s2) begin
			text_s3 <= text_d;
		end
	end

	assign out_valid = v_s3;
	assign out_text  = text_s3;

endmodule

### dv/frequency_to_decimal_text_checker.sv
// Checker for the frequency to decimal text converter: predicts each text and compares it.
`timescale 1ns / 1ps

module frequency_to_decimal_text_checker import fdt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] frequency_hz
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] mhz_hundreds_char, [11:6] mhz_tens_char, [17:12] mhz_units_char,
	// [23:18] first_dot_char, [29:24] khz_hundreds_char, [35:30] khz_tens_char,
	// [41:36] khz_units_char, [47:42] second_dot_char, [53:48] hz_hundreds_char,
	// [59:54] hz_tens_char, [63:60] zero
	input  logic [63:0] m_tdata,
	input  logic        drained,
	output int          fail_count,
	output int          pending_texts,
	output int          checked_texts
);

	localparam int unsigned NUM_CHARS = 10;
	localparam int unsigned TEXT_W    = NUM_CHARS * CHAR_W;

	// Texts still owed by the converter, oldest first.
	logic [63:0] expected_texts [$];
	logic        leftovers_counted = 1'b0;

	string char_names [NUM_CHARS] = '{
		"mhz_hundreds_char", "mhz_tens_char", "mhz_units_char", "first_dot_char",
		"khz_hundreds_char", "khz_tens_char", "khz_units_char", "second_dot_char",
		"hz_hundreds_char", "hz_tens_char"
	};

	initial begin
		fail_count    = 0;
		pending_texts = 0;
		checked_texts = 0;
	end

	// ASCII digit of the decimal place given by its weight.
	function automatic logic [CHAR_W-1:0] decimal_char(input logic [FREQ_W-1:0] freq,
			input int unsigned weight);
		return CHAR_W'((freq / weight) % 10 + ASCII_ZERO);
	endfunction

	// Builds the whole MMM.KKK.HH text as it appears on the output bus.
	function automatic logic [63:0] freq_to_text(input logic [FREQ_W-1:0] freq);
		text_t t;
		t.mhz_hundreds_char = decimal_char(freq, 100000000);
		t.mhz_tens_char     = decimal_char(freq, 10000000);
		t.mhz_units_char    = decimal_char(freq, 1000000);
		t.first_dot_char    = CHAR_W'(ASCII_DOT);
		t.khz_hundreds_char = decimal_char(freq, 100000);
		t.khz_tens_char     = decimal_char(freq, 10000);
		t.khz_units_char    = decimal_char(freq, 1000);
		t.second_dot_char   = CHAR_W'(ASCII_DOT);
		t.hz_hundreds_char  = decimal_char(freq, 100);
		t.hz_tens_char      = decimal_char(freq, 10);
		return {{(64 - TEXT_W){1'b0}}, t};
	endfunction

	// Compares every character of a received text with the oldest prediction.
	task automatic compare_text(input logic [63:0] got);
		logic [63:0] want;
		want = expected_texts.pop_front();
		for (int i = 0; i < NUM_CHARS; i++) begin
			if (got[CHAR_W*i +: CHAR_W] !== want[CHAR_W*i +: CHAR_W]) begin
				$error("%s: expected %0d, got %0d", char_names[i],
					want[CHAR_W*i +: CHAR_W], got[CHAR_W*i +: CHAR_W]);
				fail_count++;
			end
		end
		if (got[63:TEXT_W] !== want[63:TEXT_W]) begin
			$error("padding: expected %0d, got %0d", want[63:TEXT_W], got[63:TEXT_W]);
			fail_count++;
		end
		checked_texts++;
	endtask

	// Watch both channels at every edge once reset has gone.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_texts.size() == 0) begin
					$error("text: expected none, got %h", m_tdata);
					fail_count++;
				end else begin
					compare_text(m_tdata);
				end
			end
			if (s_tvalid && s_tready)
				expected_texts.push_back(freq_to_text(s_tdata));
			if (drained && !leftovers_counted) begin
				leftovers_counted = 1'b1;
				if (expected_texts.size() != 0) begin
					$error("outstanding texts: expected 0, got %0d", expected_texts.size());
					fail_count += expected_texts.size();
				end
			end
			pending_texts = expected_texts.size();
		end
	end

endmodule

### dv/frequency_to_decimal_text_tb.sv
// Testbench top for the frequency to decimal text converter: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module frequency_to_decimal_text_tb;
	import fdt_pkg::*;

	localparam int NUM_RANDOM   = 950;
	localparam int LATENCY      = 7;
	localparam int IDLE_LIMIT   = 2000;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_PERIODIC,
		READY_LONG_STALL
	} ready_mode_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [31:0] frequency_hz
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [59:0] ten six-bit characters, mhz_hundreds_char lowest, [63:60] zero
	logic [63:0] m_tdata;
	logic        drained  = 1'b0;

	int          fail_count;
	int          pending_texts;
	int          checked_texts;
	int          idle_cycles = 0;
	logic [8:0]  ready_cycle = '0;
	ready_mode_t ready_mode;

	// Boundaries of every digit, the thousands of megahertz, truncated hertz and bit patterns.
	logic [31:0] directed_freqs [22] = '{
		32'd0, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
		32'd999_999, 32'd1_000_000, 32'd999_999_999, 32'd1_000_000_000,
		32'd1_999_999_999, 32'd4_000_000_000, 32'd4_294_967_290, 32'd123_456_789,
		32'd987_654_321, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
		32'd145_800_050, 32'd7_040_019
	};

	frequency_to_decimal_text DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	frequency_to_decimal_text_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.drained       (drained),
		.fail_count    (fail_count),
		.pending_texts (pending_texts),
		.checked_texts (checked_texts)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver cycles through steady, random, periodic and long-stall patterns.
	assign ready_mode = ready_mode_t'(ready_cycle[8:7]);

	always @(posedge clk) begin
		if (arst_n) begin
			ready_cycle <= ready_cycle + 1'b1;
			case (ready_mode)
				READY_ALWAYS:     m_tready <= 1'b1;
				READY_RANDOM:     m_tready <= ($urandom_range(0, 1) == 1);
				READY_PERIODIC:   m_tready <= (ready_cycle[2:0] < 3'd3);
				READY_LONG_STALL: m_tready <= (ready_cycle[4:0] >= 5'd12);
			endcase
		end
	end

	// Watchdog: ends the run if neither channel completes a transfer for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Offers one frequency and holds it until the converter takes it.
	task automatic send_freq(input logic [31:0] freq);
		s_tdata  <= freq;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
	endtask

	// Random frequency, weighted towards digit boundaries and the megahertz extremes.
	function automatic logic [31:0] pick_freq();
		int unsigned weight;
		int unsigned digits;
		weight = 1;
		case ($urandom_range(0, 5))
			0, 1: return $urandom();
			2: begin
				repeat ($urandom_range(1, 9)) weight *= 10;
				return weight + $urandom_range(0, 40) - 20;
			end
			3: return $urandom_range(0, 999_999);
			4: return $urandom_range(1_000_000_000, 32'hFFFF_FFFF);
			default: begin
				// Nine digits are each 0 or 9, then 0 to 9 is added, so every position rolls over somewhere.
				digits = 0;
				repeat (10) begin
					digits += ($urandom_range(0, 1) ? 9 : 0) * weight;
					weight *= 10;
					if (weight > 100_000_000) break;
				end
				return digits + $urandom_range(0, 9);
			end
		endcase
	endfunction

	initial begin
		logic [31:0] freqs [$];
		int          next_item;
		int          burst_len;
		int          gap;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_freqs[i]) freqs.push_back(directed_freqs[i]);
		repeat (NUM_RANDOM) freqs.push_back(pick_freq());

		// Bursts of transfers; every third stretch of 200 items runs without gaps.
		next_item = 0;
		while (next_item < freqs.size()) begin
			burst_len = $urandom_range(1, 16);
			for (int b = 0; b < burst_len && next_item < freqs.size(); b++) begin
				send_freq(freqs[next_item]);
				next_item++;
			end
			gap = ((next_item / 200) % 3 == 2) ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (pending_texts != 0);
		repeat (3 * LATENCY) @(posedge clk);
		drained <= 1'b1;
		@(posedge clk);
		@(posedge clk);

		$display("Converted %0d frequencies (%0d at digit and range boundaries), %0d texts checked.",
			freqs.size(), $size(directed_freqs), checked_texts);
		$display("Input sent in random bursts; output back-pressure steady, random, periodic and long.");
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
